[rtl/wps_pkg.sv]
// Shared types and constants for the WAV PCM stream extractor.
package wps_pkg;

  localparam int unsigned PosW = 5;
  localparam int unsigned SizeW = 33;

  // Tags packed little-endian: byte 0 of the tag sits in bits [7:0].
  localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
  localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
  localparam logic [31:0] DATA_TAG = 32'h6174_6164;

  localparam logic [PosW-1:0] POS_RIFF_END   = PosW'(3);
  localparam logic [PosW-1:0] POS_WAVE_START = PosW'(8);
  localparam logic [PosW-1:0] POS_HDR_END    = PosW'(11);
  localparam logic [PosW-1:0] POS_CHAN_LO    = PosW'(22);
  localparam logic [PosW-1:0] POS_CHAN_HI    = PosW'(23);
  localparam logic [PosW-1:0] POS_RATE_B0    = PosW'(24);
  localparam logic [PosW-1:0] POS_RATE_B1    = PosW'(25);
  localparam logic [PosW-1:0] POS_RATE_B2    = PosW'(26);
  localparam logic [PosW-1:0] POS_RATE_B3    = PosW'(27);
  localparam logic [PosW-1:0] POS_SAT        = PosW'(28);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_DATA_FOUND = 2'd0,
    ST_NOT_WAV    = 2'd1,
    ST_NO_DATA    = 2'd2
  } status_e;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    status_e            status;
    logic [31:0]        sample_rate;
    logic [15:0]        channels;
    logic               format_valid;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [1:0] n;
    item_t      item0;
    item_t      item1;
  } res_t;

endpackage

[rtl/wps_stream_if.sv]
// Valid/ready stream interfaces for input bytes and result items.
interface wps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface wps_item_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] sample;
  logic [1:0]         status;
  logic [31:0]        sample_rate;
  logic [15:0]        channels;
  logic               format_valid;
  logic               last;

  modport source (
    output valid, output kind, output sample, output status, output sample_rate,
    output channels, output format_valid, output last, input ready
  );
  modport sink (
    input valid, input kind, input sample, input status, input sample_rate,
    input channels, input format_valid, input last, output ready
  );
endinterface

[rtl/wps_parser.sv]
// Input register and RIFF/WAVE chunk parser producing up to two result items per beat.
module wps_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  wps_byte_if.sink      byte_i,
  input  logic          buf_ready_i,
  output logic          res_valid_o,
  output wps_pkg::res_t res_o
);
  import wps_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_SKIP   = 3'd2,
    PH_DATA   = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_eob_q;

  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             magic_q, magic_d;
  logic [2:0]       fs_q, fs_d;
  logic             is_data_q, is_data_d;
  logic [SizeW-1:0] left_q, left_d;
  logic [7:0]       hold_q, hold_d;
  logic             odd_q, odd_d;
  logic [31:0]      rate_q, rate_d;
  logic [15:0]      chan_q, chan_d;
  logic             found_q, found_d;

  logic             step;
  logic             has_sample;
  logic             fmt_ok;
  item_t            sample_item, status_item;

  assign step = in_valid_q && buf_ready_i;
  assign byte_i.ready = !in_valid_q || buf_ready_i;
  assign res_valid_o = in_valid_q;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    magic_d     = magic_q;
    fs_d        = fs_q;
    is_data_d   = is_data_q;
    left_d      = left_q;
    hold_d      = hold_q;
    odd_d       = odd_q;
    rate_d      = rate_q;
    chan_d      = chan_q;
    found_d     = found_q;
    has_sample  = 1'b0;
    fmt_ok      = 1'b0;
    sample_item = '0;
    status_item = '0;

    if (pos_q == POS_CHAN_LO) chan_d[7:0] = in_byte_q;
    if (pos_q == POS_CHAN_HI) chan_d[15:8] = in_byte_q;
    if (pos_q == POS_RATE_B0) rate_d[7:0] = in_byte_q;
    if (pos_q == POS_RATE_B1) rate_d[15:8] = in_byte_q;
    if (pos_q == POS_RATE_B2) rate_d[23:16] = in_byte_q;
    if (pos_q == POS_RATE_B3) rate_d[31:24] = in_byte_q;

    case (phase_q)
      PH_HEADER: begin
        if (pos_q <= POS_RIFF_END && in_byte_q != RIFF_TAG[8*pos_q[1:0] +: 8]) begin
          magic_d = 1'b0;
        end
        if (pos_q >= POS_WAVE_START && pos_q <= POS_HDR_END &&
            in_byte_q != WAVE_TAG[8*pos_q[1:0] +: 8]) begin
          magic_d = 1'b0;
        end
        if (pos_q >= POS_HDR_END) begin
          if (magic_d) begin
            phase_d   = PH_CHUNK;
            fs_d      = '0;
            is_data_d = 1'b1;
            left_d    = '0;
          end else begin
            phase_d = PH_DONE;
          end
        end
      end
      PH_CHUNK: begin
        if (!fs_q[2]) begin
          if (in_byte_q != DATA_TAG[8*fs_q[1:0] +: 8]) is_data_d = 1'b0;
        end else begin
          left_d[8*fs_q[1:0] +: 8] = in_byte_q;
        end
        fs_d = fs_q + 3'd1;
        if (fs_q == 3'd7) begin
          if (is_data_d) begin
            found_d = 1'b1;
            odd_d   = 1'b0;
            phase_d = (left_d != '0) ? PH_DATA : PH_DONE;
          end else begin
            left_d = left_d + {{(SizeW-1){1'b0}}, left_d[0]};
            if (left_d != '0) begin
              phase_d = PH_SKIP;
            end else begin
              phase_d   = PH_CHUNK;
              fs_d      = '0;
              is_data_d = 1'b1;
            end
          end
        end
      end
      PH_SKIP: begin
        left_d = left_q - SizeW'(1);
        if (left_q == SizeW'(1)) begin
          phase_d   = PH_CHUNK;
          fs_d      = '0;
          is_data_d = 1'b1;
        end
      end
      PH_DATA: begin
        left_d = left_q - SizeW'(1);
        if (!odd_q) begin
          hold_d = in_byte_q;
          odd_d  = 1'b1;
        end else begin
          has_sample = 1'b1;
          odd_d      = 1'b0;
        end
        if (left_q == SizeW'(1)) phase_d = PH_DONE;
      end
      default: phase_d = PH_DONE;
    endcase

    pos_d = (pos_q == POS_SAT) ? pos_q : pos_q + PosW'(1);

    sample_item.kind   = KIND_SAMPLE;
    sample_item.sample = {in_byte_q, hold_q};
    sample_item.status = ST_DATA_FOUND;
    sample_item.last   = !in_eob_q;

    fmt_ok = pos_q >= POS_RATE_B3;
    status_item.kind = KIND_STATUS;
    status_item.last = 1'b1;
    if (!magic_d || pos_q < POS_HDR_END) begin
      status_item.status = ST_NOT_WAV;
    end else begin
      status_item.status       = found_d ? ST_DATA_FOUND : ST_NO_DATA;
      status_item.sample_rate  = fmt_ok ? rate_d : '0;
      status_item.channels     = fmt_ok ? chan_d : '0;
      status_item.format_valid = fmt_ok;
    end

    // End of buffer: emit status, then start over for the next buffer.
    if (in_eob_q) begin
      phase_d   = PH_HEADER;
      pos_d     = '0;
      magic_d   = 1'b1;
      fs_d      = '0;
      is_data_d = 1'b0;
      left_d    = '0;
      hold_d    = '0;
      odd_d     = 1'b0;
      rate_d    = '0;
      chan_d    = '0;
      found_d   = 1'b0;
    end

    res_o.n     = {1'b0, has_sample} + {1'b0, in_eob_q};
    res_o.item0 = has_sample ? sample_item : status_item;
    res_o.item1 = status_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      magic_q    <= 1'b1;
      fs_q       <= '0;
      is_data_q  <= 1'b0;
      left_q     <= '0;
      hold_q     <= '0;
      odd_q      <= 1'b0;
      rate_q     <= '0;
      chan_q     <= '0;
      found_q    <= 1'b0;
    end else begin
      if (byte_i.ready) in_valid_q <= byte_i.valid;
      if (step) begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        magic_q   <= magic_d;
        fs_q      <= fs_d;
        is_data_q <= is_data_d;
        left_q    <= left_d;
        hold_q    <= hold_d;
        odd_q     <= odd_d;
        rate_q    <= rate_d;
        chan_q    <= chan_d;
        found_q   <= found_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_eob_q  <= byte_i.end_of_buffer;
    end
  end

endmodule

[rtl/wps_out_buf.sv]
// Two-slot result register that drains one item per output beat.
module wps_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  wps_pkg::res_t res_i,
  output logic          buf_ready_o,
  wps_item_if.source    item_o
);
  import wps_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  item_t      s0_q, s0_d;
  item_t      s1_q, s1_d;
  logic       push, pop;

  assign pop         = item_o.valid && item_o.ready;
  assign buf_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && item_o.ready);
  assign push        = res_valid_i && buf_ready_o;

  always_comb begin
    cnt_d = cnt_q;
    s0_d  = s0_q;
    s1_d  = s1_q;
    if (push) begin
      s0_d  = res_i.item0;
      s1_d  = res_i.item1;
      cnt_d = res_i.n;
    end else if (pop) begin
      s0_d  = s1_q;
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign item_o.valid        = cnt_q != 2'd0;
  assign item_o.kind         = s0_q.kind;
  assign item_o.sample       = s0_q.sample;
  assign item_o.status       = s0_q.status;
  assign item_o.sample_rate  = s0_q.sample_rate;
  assign item_o.channels     = s0_q.channels;
  assign item_o.format_valid = s0_q.format_valid;
  assign item_o.last         = s0_q.last;

endmodule

[rtl/wav_pcm_stream_extractor.sv]
// WAV PCM stream extractor: one byte in per beat, PCM samples and a final status item out.
// Takes one byte per clock with no bubbles while the output is ready; each byte passes an
// input register and the header/chunk parser, and lands in a two-slot result register.
// A byte that completes a sample and also ends the buffer yields two items, and the result
// register drains one item per cycle while the output is ready, so such a byte holds off
// the next byte until a slot frees; otherwise one byte per cycle while the output is ready.
// After the status item all state is cleared and the next byte starts a new buffer.
module wav_pcm_stream_extractor (
  input  logic       clk_i,
  input  logic       rst_ni,
  wps_byte_if.sink   byte_i,
  wps_item_if.source item_o
);
  import wps_pkg::*;

  logic buf_ready;
  logic res_valid;
  res_t res;

  wps_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .buf_ready_i (buf_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .buf_ready_o (buf_ready),
    .item_o      (item_o)
  );

`ifndef SYNTHESIS
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_o.valid && item_o.kind == KIND_STATUS |-> item_o.last)
    else $error("status item without last");

  a_status_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_o.valid && item_o.ready && !item_o.last |=>
      item_o.valid && item_o.kind == KIND_STATUS)
    else $error("non-last beat not followed by status");

  a_not_wav_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_o.valid && item_o.kind == KIND_STATUS && item_o.status == ST_NOT_WAV |->
      item_o.sample_rate == '0 && item_o.channels == '0 && !item_o.format_valid)
    else $error("format fields set on a non-WAV status");
`endif

endmodule

[test/tb_wav_pcm_stream_extractor.sv]
// Self-checking bench for the WAV PCM stream extractor: directed rows, then random WAV buffers.
module tb_wav_pcm_stream_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import wps_pkg::*;

  typedef enum logic [2:0] {
    WALK_HDR,
    WALK_CHUNK,
    WALK_SKIP,
    WALK_DATA,
    WALK_DONE
  } walk_e;

  typedef struct packed {
    logic [7:0] b;
    logic       eob;
    logic       typed;
    item_t      want;
  } row_t;

  localparam item_t NotWavItem = '{KIND_STATUS, 16'sd0, ST_NOT_WAV, 32'd0, 16'd0, 1'b0, 1'b1};

  // typed rows carry their expected item; the rest go through the predictor
  localparam row_t DirRows[25] = '{
    '{8'h00, 1'b1, 1'b1, NotWavItem},
    '{8'h52, 1'b0, 1'b0, '0}, '{8'h49, 1'b0, 1'b0, '0},
    '{8'h46, 1'b0, 1'b0, '0}, '{8'h46, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h57, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0},
    '{8'h56, 1'b0, 1'b0, '0}, '{8'h45, 1'b0, 1'b0, '0},
    '{8'h64, 1'b0, 1'b0, '0}, '{8'h61, 1'b0, 1'b0, '0},
    '{8'h74, 1'b0, 1'b0, '0}, '{8'h61, 1'b0, 1'b0, '0},
    '{8'h05, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'h7F, 1'b1, 1'b0, '0}
  };

  localparam int IdlePct[4]  = '{0, 75, 0, 6};
  localparam int StallPct[4] = '{0, 0, 75, 6};
  localparam int BytesPerPhase = 400;
  localparam logic [31:0] FmtTag = 32'h2074_6D66;

  logic clk_i;
  logic rst_ni;

  wps_byte_if byte_ch ();
  wps_item_if item_ch ();

  wav_pcm_stream_extractor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch),
    .item_o (item_ch)
  );

  // predictor state
  logic [31:0] seen_cnt;
  walk_e       walk;
  logic        magic_good;
  logic [31:0] hdr_cnt;
  logic        is_data_chunk;
  logic [32:0] remaining;
  logic [7:0]  low_hold;
  logic        have_low;
  logic [31:0] rate_acc;
  logic [15:0] chan_acc;
  logic        found_data;

  item_t      byte_items[$];
  item_t      due_items[$];
  logic [7:0] wav_bytes[$];
  int         err_cnt = 0;
  int         src_idle = 0;
  int         stall_pct = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic log_mismatch(input string what);
    if (err_cnt < 40) $display("ERROR @%0t: %s", $realtime, what);
    err_cnt++;
  endtask

  function automatic void clear_walk();
    seen_cnt = '0;
    walk = WALK_HDR;
    magic_good = 1'b1;
    hdr_cnt = '0;
    is_data_chunk = 1'b0;
    remaining = '0;
    low_hold = '0;
    have_low = 1'b0;
    rate_acc = '0;
    chan_acc = '0;
    found_data = 1'b0;
  endfunction

  function automatic void open_chunk();
    walk = WALK_CHUNK;
    hdr_cnt = '0;
    is_data_chunk = 1'b1;
    remaining = '0;
  endfunction

  // fills byte_items with the items one accepted byte should produce
  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    logic [31:0] pos;
    item_t it;
    pos = seen_cnt;
    byte_items.delete();
    if (pos >= POS_CHAN_LO && pos <= POS_CHAN_HI)
      chan_acc |= 16'(b) << (8 * (pos - POS_CHAN_LO));
    if (pos >= POS_RATE_B0 && pos <= POS_RATE_B3)
      rate_acc |= 32'(b) << (8 * (pos - POS_RATE_B0));

    case (walk)
      WALK_HDR: begin
        if (pos <= POS_RIFF_END && b != RIFF_TAG[8 * pos[1:0] +: 8]) magic_good = 1'b0;
        if (pos >= POS_WAVE_START && pos <= POS_HDR_END &&
            b != WAVE_TAG[8 * pos[1:0] +: 8]) magic_good = 1'b0;
        if (pos >= POS_HDR_END) begin
          if (magic_good) open_chunk();
          else walk = WALK_DONE;
        end
      end
      WALK_CHUNK: begin
        if (hdr_cnt < 4) begin
          if (b != DATA_TAG[8 * hdr_cnt[1:0] +: 8]) is_data_chunk = 1'b0;
        end else begin
          remaining |= 33'(b) << (8 * hdr_cnt[1:0]);
        end
        hdr_cnt++;
        if (hdr_cnt >= 8) begin
          if (is_data_chunk) begin
            found_data = 1'b1;
            have_low = 1'b0;
            walk = (remaining != 0) ? WALK_DATA : WALK_DONE;
          end else begin
            remaining = remaining + 33'(remaining[0]);
            if (remaining != 0) walk = WALK_SKIP;
            else open_chunk();
          end
        end
      end
      WALK_SKIP: begin
        remaining--;
        if (remaining == 0) open_chunk();
      end
      WALK_DATA: begin
        remaining--;
        if (!have_low) begin
          low_hold = b;
          have_low = 1'b1;
        end else begin
          it = '0;
          it.kind = KIND_SAMPLE;
          it.sample = {b, low_hold};
          byte_items.push_back(it);
          have_low = 1'b0;
        end
        if (remaining == 0) walk = WALK_DONE;
      end
      default: walk = WALK_DONE;
    endcase

    if (seen_cnt != 32'hFFFF_FFFF) seen_cnt++;

    if (fin) begin
      it = '0;
      it.kind = KIND_STATUS;
      if (!magic_good || seen_cnt <= POS_HDR_END) begin
        it.status = ST_NOT_WAV;
      end else begin
        it.status = found_data ? ST_DATA_FOUND : ST_NO_DATA;
        if (seen_cnt >= POS_SAT) begin
          it.sample_rate = rate_acc;
          it.channels = chan_acc;
          it.format_valid = 1'b1;
        end
      end
      byte_items.push_back(it);
      clear_walk();
    end
    if (byte_items.size() > 0) byte_items[byte_items.size() - 1].last = 1'b1;
  endfunction

  task automatic check_item(input item_t got);
    item_t want;
    if (due_items.size() == 0) begin
      log_mismatch($sformatf("unexpected item kind %0d sample %0d status %0d",
                             got.kind, got.sample, got.status));
    end else begin
      want = due_items.pop_front();
      if (got.kind !== want.kind)
        log_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.sample !== want.sample)
        log_mismatch($sformatf("sample got %0d want %0d", got.sample, want.sample));
      if (got.status !== want.status)
        log_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.sample_rate !== want.sample_rate)
        log_mismatch($sformatf("sample_rate got %h want %h", got.sample_rate,
                               want.sample_rate));
      if (got.channels !== want.channels)
        log_mismatch($sformatf("channels got %h want %h", got.channels, want.channels));
      if (got.format_valid !== want.format_valid)
        log_mismatch($sformatf("format_valid got %0d want %0d", got.format_valid,
                               want.format_valid));
      if (got.last !== want.last)
        log_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
    end
  endtask

  // called right after a falling edge, returns right after a falling edge
  task automatic push_byte(input logic [7:0] b, input logic eob, input logic typed,
                           input item_t want);
    while ($urandom_range(99) < src_idle) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.end_of_buffer <= eob;
    do @(posedge clk_i); while (byte_ch.ready !== 1'b1);
    parse_byte(b, eob);
    if (typed) due_items.push_back(want);
    else foreach (byte_items[k]) due_items.push_back(byte_items[k]);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    byte_ch.valid <= 1'b0;
    while (due_items.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
  endtask

  function automatic void put32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) wav_bytes.push_back(v[8 * k +: 8]);
  endfunction

  function automatic void put_body(input int n);
    for (int k = 0; k < n; k++) wav_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // one buffer: mostly well-formed WAV, some noise, broken magic or truncation
  function automatic void build_wav();
    int sel;
    int sz;
    int dlen;
    int n_extra;
    int idx;
    int len;
    logic [31:0] id;
    wav_bytes.delete();
    sel = $urandom_range(99);
    if (sel < 8) begin
      put_body($urandom_range(1, 30));
      return;
    end
    put32(RIFF_TAG);
    put32($urandom);
    put32(WAVE_TAG);
    if ($urandom_range(3) != 0) begin
      sz = $urandom_range(14, 18);
      put32(FmtTag);
      put32(sz);
      put_body(sz + (sz % 2));
    end
    n_extra = $urandom_range(0, 2);
    for (int c = 0; c < n_extra; c++) begin
      id = $urandom_range(1) ? DATA_TAG ^ (32'd1 << $urandom_range(31)) : $urandom;
      sz = $urandom_range(0, 9);
      put32(id);
      put32(sz);
      put_body(sz + (sz % 2));
    end
    if ($urandom_range(9) != 0) begin
      sz = $urandom_range(0, 40);
      if ($urandom_range(9) == 0) sz = $urandom;
      put32(DATA_TAG);
      put32(sz);
      dlen = (sz > 40 || sz < 0) ? $urandom_range(0, 40) : sz;
      put_body(dlen);
      if (dlen == sz) put_body($urandom_range(0, 4));
    end else if ($urandom_range(1) != 0) begin
      put32($urandom);
      put32($urandom | 32'h100);
      put_body($urandom_range(0, 6));
    end
    if (sel < 20) begin
      idx = $urandom_range(7);
      idx = (idx < 4) ? idx : idx + 4;
      wav_bytes[idx] ^= 8'(1 << $urandom_range(7));
    end
    if ($urandom_range(4) == 0) begin
      len = $urandom_range(1, wav_bytes.size());
      wav_bytes = wav_bytes[0:len - 1];
    end
  endfunction

  initial begin
    item_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      item_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    item_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
        got.kind = item_ch.kind;
        got.sample = item_ch.sample;
        got.status = status_e'(item_ch.status);
        got.sample_rate = item_ch.sample_rate;
        got.channels = item_ch.channels;
        got.format_valid = item_ch.format_valid;
        got.last = item_ch.last;
        check_item(got);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("wav_pcm_stream_extractor: mismatch");
    $finish;
  end

  initial begin
    int sent;
    rst_ni = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.end_of_buffer = 1'b0;
    clear_walk();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirRows[r]) push_byte(DirRows[r].b, DirRows[r].eob, DirRows[r].typed, DirRows[r].want);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      src_idle = IdlePct[p];
      stall_pct = StallPct[p];
      sent = 0;
      while (sent < BytesPerPhase) begin
        build_wav();
        foreach (wav_bytes[i]) push_byte(wav_bytes[i], i == wav_bytes.size() - 1, 1'b0, '0);
        sent += wav_bytes.size();
      end
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (due_items.size() != 0)
      log_mismatch($sformatf("%0d expected items never arrived", due_items.size()));
    if (err_cnt == 0) begin
      $display("wav_pcm_stream_extractor: match");
    end else begin
      $display("wav_pcm_stream_extractor: mismatch");
    end
    $finish;
  end

endmodule
